/* rtl/lav_pkg.sv */
// ----------------------------------------------------------------------------
// lav_pkg
// Shared constants and types for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 32;

  // vector normalization
  localparam int NW       = FRAC_BITS + 34;
  localparam int MAG_W    = NW;
  localparam int SCL_W    = 30;
  localparam int SH_STEPS = 6;
  localparam int SQ_W     = 2 * SCL_W + 2;
  localparam int ROOT_W   = SCL_W + 1;
  localparam int Q_W      = FRAC_BITS + 1;
  localparam int NV_W     = Q_W + 1;
  localparam int NUM_W    = SCL_W + FRAC_BITS + 1;

  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT  = Q_W;
  localparam int NORM_LAT = 1 + SH_STEPS + 2 + SQRT_LAT + 1 + DIV_LAT + 1;

  // products and dot terms
  localparam int U_W     = NV_W + 2;
  localparam int DOT_W   = U_W + IN_W + 4;
  localparam int ROUND_C = 1 << (FRAC_BITS - 1);

  localparam logic [IN_W-1:0] ONE_VAL  = IN_W'(1) << FRAC_BITS;
  localparam logic [1:0]      LAST_COL = 2'd3;

  typedef logic signed [NW-1:0]   nin_t;
  typedef logic signed [NV_W-1:0] nv_t;

  typedef struct packed {
    logic [2:0][NV_W-1:0] s;
    logic [2:0][U_W-1:0]  u;
    logic [2:0][NV_W-1:0] f;
    logic [2:0][IN_W-1:0] t;
  } mat_t;

endpackage

`default_nettype wire

/* rtl/lav_sqrt.sv */
// ----------------------------------------------------------------------------
// lav_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_sqrt import lav_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   x,
  output logic [ROOT_W-1:0] root
);

  logic [SQ_W-1:0]   rem_r [ROOT_W];
  logic [ROOT_W-1:0] rt_r  [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_st
    localparam int B = ROOT_W - 1 - g;
    logic [SQ_W-1:0]   rem_src;
    logic [ROOT_W-1:0] rt_src;
    logic [SQ_W+1:0]   trial;

    if (g == 0) begin : g_first
      assign rem_src = x;
      assign rt_src  = '0;
    end else begin : g_next
      assign rem_src = rem_r[g-1];
      assign rt_src  = rt_r[g-1];
    end

    assign trial = ((SQ_W+2)'(rt_src) << (B + 1)) | ((SQ_W+2)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({2'b00, rem_src} >= trial) begin
          rem_r[g] <= rem_src - trial[SQ_W-1:0];
          rt_r[g]  <= rt_src | (ROOT_W'(1) << B);
        end else begin
          rem_r[g] <= rem_src;
          rt_r[g]  <= rt_src;
        end
      end
    end
  end

  assign root = rt_r[ROOT_W-1];

endmodule

`default_nettype wire

/* rtl/lav_div.sv */
// ----------------------------------------------------------------------------
// lav_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_div import lav_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [ROOT_W-1:0] den,
  output logic [Q_W-1:0]    quo
);

  logic [NUM_W-1:0]  rem_r [Q_W];
  logic [ROOT_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]    q_r   [Q_W];

  for (genvar g = 0; g < Q_W; g++) begin : g_st
    localparam int J = Q_W - 1 - g;
    logic [NUM_W-1:0]  rem_src;
    logic [ROOT_W-1:0] den_src;
    logic [Q_W-1:0]    q_src;
    logic [NUM_W:0]    dsh;

    if (g == 0) begin : g_first
      assign rem_src = num;
      assign den_src = den;
      assign q_src   = '0;
    end else begin : g_next
      assign rem_src = rem_r[g-1];
      assign den_src = den_r[g-1];
      assign q_src   = q_r[g-1];
    end

    assign dsh = (NUM_W+1)'(den_src) << J;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[g] <= den_src;
        if ({1'b0, rem_src} >= dsh) begin
          rem_r[g] <= rem_src - dsh[NUM_W-1:0];
          q_r[g]   <= q_src | (Q_W'(1) << J);
        end else begin
          rem_r[g] <= rem_src;
          q_r[g]   <= q_src;
        end
      end
    end
  end

  assign quo = q_r[Q_W-1];

endmodule

`default_nettype wire

/* rtl/lav_norm.sv */
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalization: scale, sum of squares, root, divide.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_norm import lav_pkg::*; (
  input  logic clk,
  input  logic en,
  input  nin_t vec_in  [3],
  output nv_t  vec_out [3]
);

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } nfl_t;

  logic [MAG_W-1:0]   mag_nxt [3];
  logic [MAG_W-1:0]   max_nxt;
  nfl_t               fl_nxt;
  nfl_t               fl_r   [NORM_LAT-1];
  logic [MAG_W-1:0]   mv_r   [SH_STEPS+1][3];
  logic [MAG_W-1:0]   mm_r   [SH_STEPS+1];
  logic [2*SCL_W-1:0] sq_r   [3];
  logic [SQ_W-1:0]    sum_r;
  logic [SCL_W-1:0]   mgd_r  [SQRT_LAT+2][3];
  logic [ROOT_W-1:0]  root;
  logic [NUM_W-1:0]   num_r  [3];
  logic [ROOT_W-1:0]  den_r;
  logic [Q_W-1:0]     quo    [3];
  nv_t                out_r  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fl_nxt.neg[i] = vec_in[i][NW-1];
      mag_nxt[i]    = vec_in[i][NW-1] ? MAG_W'(-vec_in[i]) : MAG_W'(vec_in[i]);
    end
    max_nxt = mag_nxt[0];
    if (mag_nxt[1] > max_nxt) max_nxt = mag_nxt[1];
    if (mag_nxt[2] > max_nxt) max_nxt = mag_nxt[2];
    fl_nxt.zero = (max_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) mv_r[0][i] <= mag_nxt[i];
      mm_r[0]  <= max_nxt;
      fl_r[0]  <= fl_nxt;
      for (int k = 1; k < NORM_LAT - 1; k++) fl_r[k] <= fl_r[k-1];
    end
  end

  // left-justify by the largest magnitude, binary steps
  for (genvar k = 0; k < SH_STEPS; k++) begin : g_sh
    localparam int AMT = 1 << (SH_STEPS - 1 - k);
    always_ff @(posedge clk) begin
      if (en) begin
        if (mm_r[k][MAG_W-1 -: AMT] == '0) begin
          mm_r[k+1] <= mm_r[k] << AMT;
          for (int i = 0; i < 3; i++) mv_r[k+1][i] <= mv_r[k][i] << AMT;
        end else begin
          mm_r[k+1] <= mm_r[k];
          for (int i = 0; i < 3; i++) mv_r[k+1][i] <= mv_r[k][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i]     <= mv_r[SH_STEPS][i][MAG_W-1 -: SCL_W] *
                       mv_r[SH_STEPS][i][MAG_W-1 -: SCL_W];
        mgd_r[0][i] <= mv_r[SH_STEPS][i][MAG_W-1 -: SCL_W];
      end
      sum_r <= SQ_W'(sq_r[0]) + SQ_W'(sq_r[1]) + SQ_W'(sq_r[2]);
      for (int k = 1; k < SQRT_LAT + 2; k++) begin
        for (int i = 0; i < 3; i++) mgd_r[k][i] <= mgd_r[k-1][i];
      end
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (NUM_W'(mgd_r[SQRT_LAT+1][i]) << FRAC_BITS) + NUM_W'(root >> 1);
      end
      den_r <= root;
      for (int i = 0; i < 3; i++) begin
        if (fl_r[NORM_LAT-2].zero) begin
          out_r[i] <= '0;
        end else if (fl_r[NORM_LAT-2].neg[i]) begin
          out_r[i] <= -nv_t'(quo[i]);
        end else begin
          out_r[i] <= nv_t'(quo[i]);
        end
      end
    end
  end

  lav_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (sum_r),
    .root (root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    lav_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_r[i]),
      .den (den_r),
      .quo (quo[i])
    );
  end

  assign vec_out = out_r;

endmodule

`default_nettype wire

/* rtl/lav_ser.sv */
// ----------------------------------------------------------------------------
// lav_ser
// Output stage: holds one matrix and sends it as four column transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_ser import lav_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   ld_valid,
  input  mat_t                   ld_mat,
  output logic                   ld_ready,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_column_index,
  output logic signed [IN_W-1:0] out_row_0,
  output logic signed [IN_W-1:0] out_row_1,
  output logic signed [IN_W-1:0] out_row_2,
  output logic signed [IN_W-1:0] out_row_3,
  output logic                   out_last
);

  logic       busy_r;
  logic [1:0] col_r;
  mat_t       mat_r;

  assign ld_ready = !busy_r || (col_r == LAST_COL && !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      col_r  <= '0;
    end else if (ld_valid && ld_ready) begin
      busy_r <= 1'b1;
      col_r  <= '0;
    end else if (busy_r && !out_stall) begin
      if (col_r == LAST_COL) begin
        busy_r <= 1'b0;
      end
      col_r <= col_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid && ld_ready) mat_r <= ld_mat;
  end

  always_comb begin
    out_valid        = busy_r;
    out_column_index = col_r;
    out_last         = (col_r == LAST_COL);
    if (col_r == LAST_COL) begin
      out_row_0 = signed'(mat_r.t[0]);
      out_row_1 = signed'(mat_r.t[1]);
      out_row_2 = signed'(mat_r.t[2]);
      out_row_3 = signed'(ONE_VAL);
    end else begin
      out_row_0 = IN_W'(signed'(mat_r.s[col_r]));
      out_row_1 = IN_W'(signed'(mat_r.u[col_r]));
      out_row_2 = -IN_W'(signed'(mat_r.f[col_r]));
      out_row_3 = '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/look_at_view_matrix.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Throughput: set by the four-column output stage, which takes a new matrix
// as its last column goes out; the pipeline itself takes a new transaction
// every cycle while in_stall is low (a full final stage stalls it).
// Reset: synchronous, active low, clears all valid bits and the output busy flag and column.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix import lav_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [IN_W-1:0] in_eye_x,
  input  logic signed [IN_W-1:0] in_eye_y,
  input  logic signed [IN_W-1:0] in_eye_z,
  input  logic signed [IN_W-1:0] in_target_x,
  input  logic signed [IN_W-1:0] in_target_y,
  input  logic signed [IN_W-1:0] in_target_z,
  input  logic signed [IN_W-1:0] in_up_x,
  input  logic signed [IN_W-1:0] in_up_y,
  input  logic signed [IN_W-1:0] in_up_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_column_index,
  output logic signed [IN_W-1:0] out_row_0,
  output logic signed [IN_W-1:0] out_row_1,
  output logic signed [IN_W-1:0] out_row_2,
  output logic signed [IN_W-1:0] out_row_3,
  output logic                   out_last
);

  localparam int TOT  = 2 * NORM_LAT + 8;
  localparam int XP_W = NV_W + IN_W;
  localparam int YP_W = 2 * NV_W;

  logic adv;
  logic ser_ready;
  logic vld_r [TOT+1];

  logic signed [IN_W-1:0] eye0_r [3];
  logic signed [IN_W-1:0] tgt0_r [3];
  logic signed [IN_W-1:0] up0_r  [3];

  nin_t                   fraw_r [3];
  logic signed [IN_W-1:0] eye1_r [3];
  logic signed [IN_W-1:0] up1_r  [3];
  logic signed [IN_W-1:0] ea_r   [NORM_LAT][3];
  logic signed [IN_W-1:0] ua_r   [NORM_LAT][3];
  nv_t                    fn     [3];

  logic signed [XP_W-1:0] xp_r   [6];
  nv_t                    fx1_r  [3];
  logic signed [IN_W-1:0] ex1_r  [3];
  nin_t                   sraw_r [3];
  nv_t                    fx2_r  [3];
  logic signed [IN_W-1:0] ex2_r  [3];
  nv_t                    fb_r   [NORM_LAT][3];
  logic signed [IN_W-1:0] eb_r   [NORM_LAT][3];
  nv_t                    sn     [3];

  logic signed [YP_W-1:0] yp_r   [6];
  nv_t                    sy1_r  [3];
  nv_t                    fy1_r  [3];
  logic signed [IN_W-1:0] ey1_r  [3];
  logic signed [U_W-1:0]  u_nxt  [3];
  logic signed [U_W-1:0]  uy2_r  [3];
  nv_t                    sy2_r  [3];
  nv_t                    fy2_r  [3];
  logic signed [IN_W-1:0] ey2_r  [3];

  logic signed [DOT_W-1:0] dp_r  [9];
  logic signed [U_W-1:0]   ud1_r [3];
  nv_t                     sd1_r [3];
  nv_t                     fd1_r [3];
  logic signed [DOT_W-1:0] ds_r  [3];
  logic signed [U_W-1:0]   ud2_r [3];
  nv_t                     sd2_r [3];
  nv_t                     fd2_r [3];
  mat_t                    mat_nxt;
  mat_t                    mat_r;

  function automatic logic [IN_W-1:0] sat32(input logic signed [DOT_W-1:0] x);
    if (x[DOT_W-1:IN_W-1] == '0 || x[DOT_W-1:IN_W-1] == '1) begin
      return x[IN_W-1:0];
    end
    return x[DOT_W-1] ? {1'b1, {(IN_W-1){1'b0}}} : {1'b0, {(IN_W-1){1'b1}}};
  endfunction

  assign adv      = !vld_r[TOT] || ser_ready;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= TOT; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k <= TOT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // input capture, forward difference, side data for the first normalizer
  always_ff @(posedge clk) begin
    if (adv) begin
      eye0_r <= '{in_eye_x, in_eye_y, in_eye_z};
      tgt0_r <= '{in_target_x, in_target_y, in_target_z};
      up0_r  <= '{in_up_x, in_up_y, in_up_z};
      for (int i = 0; i < 3; i++) begin
        fraw_r[i] <= NW'(tgt0_r[i]) - NW'(eye0_r[i]);
        ea_r[0][i] <= eye1_r[i];
        ua_r[0][i] <= up1_r[i];
        for (int k = 1; k < NORM_LAT; k++) begin
          ea_r[k][i] <= ea_r[k-1][i];
          ua_r[k][i] <= ua_r[k-1][i];
        end
      end
      eye1_r <= eye0_r;
      up1_r  <= up0_r;
    end
  end

  lav_norm u_norm_f (
    .clk     (clk),
    .en      (adv),
    .vec_in  (fraw_r),
    .vec_out (fn)
  );

  // s = f x up
  always_ff @(posedge clk) begin
    if (adv) begin
      xp_r[0] <= fn[1] * ua_r[NORM_LAT-1][2];
      xp_r[1] <= fn[2] * ua_r[NORM_LAT-1][1];
      xp_r[2] <= fn[2] * ua_r[NORM_LAT-1][0];
      xp_r[3] <= fn[0] * ua_r[NORM_LAT-1][2];
      xp_r[4] <= fn[0] * ua_r[NORM_LAT-1][1];
      xp_r[5] <= fn[1] * ua_r[NORM_LAT-1][0];
      fx1_r   <= fn;
      ex1_r   <= ea_r[NORM_LAT-1];
      for (int i = 0; i < 3; i++) begin
        sraw_r[i] <= NW'(xp_r[2*i]) - NW'(xp_r[2*i+1]);
      end
      fx2_r <= fx1_r;
      ex2_r <= ex1_r;
      for (int i = 0; i < 3; i++) begin
        fb_r[0][i] <= fx2_r[i];
        eb_r[0][i] <= ex2_r[i];
        for (int k = 1; k < NORM_LAT; k++) begin
          fb_r[k][i] <= fb_r[k-1][i];
          eb_r[k][i] <= eb_r[k-1][i];
        end
      end
    end
  end

  lav_norm u_norm_s (
    .clk     (clk),
    .en      (adv),
    .vec_in  (sraw_r),
    .vec_out (sn)
  );

  // u = s x f, rounded back to the fixed-point scale
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [YP_W:0] d;
      d        = (YP_W+1)'(yp_r[2*i]) - (YP_W+1)'(yp_r[2*i+1]);
      d        = (d + ROUND_C) >>> FRAC_BITS;
      u_nxt[i] = d[U_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yp_r[0] <= sn[1] * fb_r[NORM_LAT-1][2];
      yp_r[1] <= sn[2] * fb_r[NORM_LAT-1][1];
      yp_r[2] <= sn[2] * fb_r[NORM_LAT-1][0];
      yp_r[3] <= sn[0] * fb_r[NORM_LAT-1][2];
      yp_r[4] <= sn[0] * fb_r[NORM_LAT-1][1];
      yp_r[5] <= sn[1] * fb_r[NORM_LAT-1][0];
      sy1_r   <= sn;
      fy1_r   <= fb_r[NORM_LAT-1];
      ey1_r   <= eb_r[NORM_LAT-1];
      uy2_r   <= u_nxt;
      sy2_r   <= sy1_r;
      fy2_r   <= fy1_r;
      ey2_r   <= ey1_r;
    end
  end

  // translation dot products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dp_r[i]   <= sy2_r[i] * ey2_r[i];
        dp_r[3+i] <= uy2_r[i] * ey2_r[i];
        dp_r[6+i] <= fy2_r[i] * ey2_r[i];
      end
      sd1_r <= sy2_r;
      ud1_r <= uy2_r;
      fd1_r <= fy2_r;
      for (int j = 0; j < 3; j++) begin
        ds_r[j] <= dp_r[3*j] + dp_r[3*j+1] + dp_r[3*j+2];
      end
      sd2_r <= sd1_r;
      ud2_r <= ud1_r;
      fd2_r <= fd1_r;
      mat_r <= mat_nxt;
    end
  end

  always_comb begin
    logic signed [DOT_W-1:0] r [3];
    for (int j = 0; j < 3; j++) begin
      r[j] = (ds_r[j] + ROUND_C) >>> FRAC_BITS;
    end
    for (int i = 0; i < 3; i++) begin
      mat_nxt.s[i] = sd2_r[i];
      mat_nxt.u[i] = ud2_r[i];
      mat_nxt.f[i] = fd2_r[i];
    end
    mat_nxt.t[0] = sat32(-r[0]);
    mat_nxt.t[1] = sat32(-r[1]);
    mat_nxt.t[2] = sat32(r[2]);
  end

  lav_ser u_ser (
    .clk              (clk),
    .rst_n            (rst_n),
    .ld_valid         (vld_r[TOT]),
    .ld_mat           (mat_r),
    .ld_ready         (ser_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_index (out_column_index),
    .out_row_0        (out_row_0),
    .out_row_1        (out_row_1),
    .out_row_2        (out_row_2),
    .out_row_3        (out_row_3),
    .out_last         (out_last)
  );

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[TOT] |-> !in_stall)
    else $error("input stalled with an empty final stage");

  a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && out_column_index == 2'($past(out_column_index) + 2'd1))
    else $error("column sequence broken");

  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_column_index == LAST_COL)))
    else $error("last flag does not match column");

  a_first_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last && vld_r[TOT] |=>
      out_valid && out_column_index == '0)
    else $error("waiting matrix not loaded after last column");

endmodule

`default_nettype wire

/* bench/lav_checker.sv */
// ----------------------------------------------------------------------------
// lav_checker
// Watches both channels of the look-at view matrix block, predicts the four
// columns of each accepted transaction and compares them field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lav_checker import lav_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic signed [IN_W-1:0] in_eye_x,
  input  logic signed [IN_W-1:0] in_eye_y,
  input  logic signed [IN_W-1:0] in_eye_z,
  input  logic signed [IN_W-1:0] in_target_x,
  input  logic signed [IN_W-1:0] in_target_y,
  input  logic signed [IN_W-1:0] in_target_z,
  input  logic signed [IN_W-1:0] in_up_x,
  input  logic signed [IN_W-1:0] in_up_y,
  input  logic signed [IN_W-1:0] in_up_z,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [1:0]             out_column_index,
  input  logic signed [IN_W-1:0] out_row_0,
  input  logic signed [IN_W-1:0] out_row_1,
  input  logic signed [IN_W-1:0] out_row_2,
  input  logic signed [IN_W-1:0] out_row_3,
  input  logic                   out_last,
  output int                     errors,
  output int                     pending,
  output int                     columns_seen
);

  typedef struct {
    logic [1:0]             idx;
    logic signed [IN_W-1:0] r0;
    logic signed [IN_W-1:0] r1;
    logic signed [IN_W-1:0] r2;
    logic signed [IN_W-1:0] r3;
    logic                   lst;
  } column_t;

  typedef longint vec3_t [3];

  column_t expected_cols [$];

  function automatic longint floor_shr(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint round_q(longint x);
    return floor_shr(x + ROUND_C, FRAC_BITS);
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic vec3_t unit_vec(vec3_t v);
    longint unsigned mag [3];
    longint unsigned m, sum, len, q;
    bit neg [3];
    vec3_t r;
    m = 0;
    sum = 0;
    r = v;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? 64'd0 - longint'(v[i]) : longint'(v[i]);
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return r;
    while (m >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
      m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
      m <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FRAC_BITS) + (len >> 1)) / len;
      r[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return r;
  endfunction

  function automatic vec3_t cross3(vec3_t a, vec3_t b);
    vec3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic longint dot(vec3_t a, vec3_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  task automatic predict_matrix();
    vec3_t eye, upv, fwd, side, tup;
    longint col [4][4];
    column_t c;
    eye = '{longint'(in_eye_x), longint'(in_eye_y), longint'(in_eye_z)};
    upv = '{longint'(in_up_x), longint'(in_up_y), longint'(in_up_z)};
    fwd = '{longint'(in_target_x) - eye[0], longint'(in_target_y) - eye[1],
            longint'(in_target_z) - eye[2]};
    fwd  = unit_vec(fwd);
    side = unit_vec(cross3(fwd, upv));
    tup  = cross3(side, fwd);
    for (int i = 0; i < 3; i++) tup[i] = round_q(tup[i]);
    for (int k = 0; k < 3; k++) begin
      col[k][0] = side[k];
      col[k][1] = tup[k];
      col[k][2] = -fwd[k];
      col[k][3] = 0;
    end
    col[3][0] = clamp32(-round_q(dot(side, eye)));
    col[3][1] = clamp32(-round_q(dot(tup, eye)));
    col[3][2] = clamp32(round_q(dot(fwd, eye)));
    col[3][3] = longint'(1) << FRAC_BITS;
    for (int k = 0; k < 4; k++) begin
      c.idx = k[1:0];
      c.r0  = clamp32(col[k][0]);
      c.r1  = clamp32(col[k][1]);
      c.r2  = clamp32(col[k][2]);
      c.r3  = clamp32(col[k][3]);
      c.lst = (k[1:0] == LAST_COL);
      expected_cols.push_back(c);
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    columns_seen = 0;
  end

  always @(posedge clk) begin
    column_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_matrix();
      if (out_valid && !out_stall) begin
        columns_seen++;
        if (expected_cols.size() == 0) begin
          report("unexpected column", out_column_index, 0);
        end else begin
          e = expected_cols.pop_front();
          if (out_column_index !== e.idx) report("column_index", out_column_index, e.idx);
          if (out_row_0 !== e.r0) report("row_0", out_row_0, e.r0);
          if (out_row_1 !== e.r1) report("row_1", out_row_1, e.r1);
          if (out_row_2 !== e.r2) report("row_2", out_row_2, e.r2);
          if (out_row_3 !== e.r3) report("row_3", out_row_3, e.r3);
          if (out_last !== e.lst) report("last", out_last, e.lst);
        end
      end
    end
    pending = expected_cols.size();
  end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives eye/target/up transactions into the look-at view matrix block with
// bursty input and random output stalls; the checker scores every column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lav_pkg::*;

  localparam int LATENCY     = 128;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_HOLD      = 160;
  localparam int N_RANDOM    = 58;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [IN_W-1:0] in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  logic signed [IN_W-1:0] in_target_x = '0, in_target_y = '0, in_target_z = '0;
  logic signed [IN_W-1:0] in_up_x = '0, in_up_y = '0, in_up_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_column_index;
  logic signed [IN_W-1:0] out_row_0, out_row_1, out_row_2, out_row_3;
  logic out_last;
  int errors, pending, columns_seen;
  int cycles = 0;
  int sent = 0;
  bit hold_out = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  look_at_view_matrix DUT (.*);

  lav_checker u_checker (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver: random stall pattern, or a forced long hold-off
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(4, 40)) begin
        @(posedge clk);
        if (hold_out) out_stall <= 1'b1;
        else if (mode == 0) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 9) < mode * 2);
      end
    end
  end

  function automatic logic [IN_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return $urandom;
      4: return 32'(int'($urandom_range(0, 40 << 16)) - (20 << 16));
      default: return 32'(int'($urandom_range(0, 2000)) - 1000) <<< $urandom_range(0, 16);
    endcase
  endfunction

  task automatic send(logic [IN_W-1:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
    in_valid <= 1'b1;
    in_eye_x <= ex; in_eye_y <= ey; in_eye_z <= ez;
    in_target_x <= tx; in_target_y <= ty; in_target_z <= tz;
    in_up_x <= ux; in_up_y <= uy; in_up_z <= uz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [IN_W-1:0] ex, ey, ez;
    int burst;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send(0, 0, 0, 0, 0, 32'hffff_0000, 0, 32'h0001_0000, 0);
    send(32'h0005_0000, 32'h0002_0000, 32'h000a_0000, 0, 0, 0, 0, 32'h0001_0000, 0);
    send(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
         32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000, 0);          // eye on target
    send(0, 0, 0, 32'h0003_0000, 0, 0, 0, 0, 0);                       // zero up
    send(0, 0, 0, 0, 32'h0004_0000, 0, 0, 32'h0001_0000, 0);           // up along forward
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
         32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
    send(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
         32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 32'h8000_0000,
         32'h0001_0000, 0, 0);                                         // saturating translation
    send(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 1, 0, 0);
    send(0, 0, 0, 1, 0, 0, 0, 0, 1);                                   // tiny vectors
    send(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
         32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
         32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);

    // sender pauses until everything has drained
    wait_drained();

    // receiver holds off while the sender keeps offering
    fork
      begin
        hold_out = 1'b1;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end
      repeat (N_HOLD)
        send(pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
             pick_value(), pick_value(), pick_value(), pick_value());
    join

    while (sent < 12 + N_HOLD + N_RANDOM) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        ex = pick_value(); ey = pick_value(); ez = pick_value();
        if ($urandom_range(0, 9) == 0)
          send(ex, ey, ez, ex, ey, ez, pick_value(), pick_value(), pick_value());
        else
          send(ex, ey, ez, pick_value(), pick_value(), pick_value(),
               pick_value(), pick_value(), pick_value());
      end
      if ($urandom_range(0, 2) != 0) gap();
    end

    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);
    $display("covered %0d matrices, %0d columns checked, corners and long stalls included",
             sent, columns_seen);
    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lav_pkg.sv
rtl/lav_sqrt.sv
rtl/lav_div.sv
rtl/lav_norm.sv
rtl/lav_ser.sv
rtl/look_at_view_matrix.sv
bench/lav_checker.sv
bench/testbench.sv
